// ----- design/kts_pkg.sv -----
package kts_pkg;

    localparam int DEFAULT_KEY_DEPTH = 64;
    localparam int SLOT_LIMIT = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // register byte addresses
    localparam logic [1:0] ADDR_KEY_COUNT = 2'd0;

    localparam logic [16:0] ONE_WEIGHT = 17'h10000;

    // one classified item between front and back
    typedef struct packed {
        logic        kind;
        logic [5:0]  slot;
        logic [31:0] key_time;
        logic [31:0] value_x;
        logic [31:0] value_y;
        logic [31:0] value_z;
        logic [31:0] query_time;
    } kts_item_t;

    // one result beat
    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic [5:0]  segment_index;
        logic [16:0] blend_weight;
    } kts_result_t;

endpackage

// ----- design/keyframe_track_sampler_unit.sv -----
// Keyframe track sampler: holds up to KEY_DEPTH keys, at most 64 (time and
// xyz value, signed Q16.16). A load beat (tuser 0) writes one key slot and
// gives no result; a query beat (tuser 1) gives one result beat with the
// linearly interpolated value, the segment index and the Q1.16 weight. Key
// times must be loaded in nondecreasing order. A query that clamps to the
// first or last key skips the search; otherwise the cached forward search
// does one key-store read and compare per segment visited, then a
// bit-serial divide (17 quotient bits and the weight load) and the blend.
// A cached segment at or beyond a lowered key_count is first brought below
// the count by repeated subtraction. A two-entry queue sits between the
// input and the sequencer. key_count is at APB address 0.
module keyframe_track_sampler_unit #(
    parameter int KEY_DEPTH = kts_pkg::DEFAULT_KEY_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tuser,   // kind
    // key_slot, key_time, value_x, value_y, value_z, query_time
    input  logic [175:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_z, segment_index, blend_weight
    output logic [119:0] m_tdata
);
    import kts_pkg::*;

    logic [6:0]  key_count_reg;
    logic        q_valid, q_ready;
    kts_item_t   q_item;
    kts_result_t r_data;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_KEY_COUNT) ? {25'd0, key_count_reg} : 32'd0;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) key_count_reg <= 7'd1;
        else if (psel && penable && pwrite && paddr == ADDR_KEY_COUNT)
            key_count_reg <= pwdata[6:0];
    end

    kts_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser),
        .s_tdata(s_tdata[165:0]),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    kts_back #(.KEY_DEPTH(KEY_DEPTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .key_count(key_count_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .r_valid(m_tvalid), .r_ready(m_tready), .r_data(r_data)
    );

    assign m_tdata = {1'b0, r_data.blend_weight, r_data.segment_index,
                      r_data.out_z, r_data.out_y, r_data.out_x};

endmodule

// ----- design/kts_front.sv -----
module kts_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tuser,
    input  logic [165:0]      s_tdata,
    output logic              q_valid,
    input  logic              q_ready,
    output kts_pkg::kts_item_t q_item
);
    import kts_pkg::*;

    kts_item_t  buf_reg [QUEUE_DEPTH];
    logic [1:0] count_reg;
    logic       wptr_reg;
    logic       rptr_reg;
    kts_item_t  in_item;
    logic       push;
    logic       pop;

    // unpack the beat into item fields
    always_comb begin
        in_item.kind       = s_tuser;
        in_item.slot       = s_tdata[5:0];
        in_item.key_time   = s_tdata[37:6];
        in_item.value_x    = s_tdata[69:38];
        in_item.value_y    = s_tdata[101:70];
        in_item.value_z    = s_tdata[133:102];
        in_item.query_time = s_tdata[165:134];
    end

    assign s_tready = (count_reg != 2'(QUEUE_DEPTH));
    assign push = s_tvalid && s_tready;
    assign q_valid = (count_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_item = buf_reg[rptr_reg];

    // two-entry queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop) rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) buf_reg[wptr_reg] <= in_item;
    end

endmodule

// ----- design/kts_back.sv -----
module kts_back #(
    parameter int KEY_DEPTH = kts_pkg::DEFAULT_KEY_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [6:0]          key_count,
    input  logic                q_valid,
    output logic                q_ready,
    input  kts_pkg::kts_item_t  q_item,
    output logic                r_valid,
    input  logic                r_ready,
    output kts_pkg::kts_result_t r_data
);
    import kts_pkg::*;

    localparam int AW = $clog2(KEY_DEPTH);
    localparam int CW = $clog2(KEY_DEPTH + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RD0   = 4'd1;
    localparam logic [3:0] ST_RDL   = 4'd2;
    localparam logic [3:0] ST_CHKL  = 4'd3;
    localparam logic [3:0] ST_SRD   = 4'd4;
    localparam logic [3:0] ST_SCHK  = 4'd5;
    localparam logic [3:0] ST_FETCH = 4'd6;
    localparam logic [3:0] ST_FWAIT = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_MUL   = 4'd9;
    localparam logic [3:0] ST_SUM   = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;
    localparam logic [3:0] ST_FREAD = 4'd12;

    // key stores, two read ports
    logic [31:0] t_mem [KEY_DEPTH];
    logic [31:0] x_mem [KEY_DEPTH];
    logic [31:0] y_mem [KEY_DEPTH];
    logic [31:0] z_mem [KEY_DEPTH];
    logic [AW-1:0] ra_a, ra_b;
    logic [31:0] ta_reg, tb_reg, xa_reg, xb_reg, ya_reg, yb_reg, za_reg, zb_reg;

    logic [3:0]    state_reg;
    logic [CW-1:0] n_reg;
    logic [AW-1:0] cache_reg, j_reg, c_reg, cnt_reg;
    logic [AW-1:0] aa_reg, ab_reg;
    logic [31:0]   q_reg;
    logic [32:0]   rem_reg, den_reg;
    logic [16:0]   quo_reg;
    logic [4:0]    bit_reg;
    logic [16:0]   w_reg;
    logic [65:0]   px_reg, py_reg, pz_reg;
    kts_result_t   res_reg;
    logic          res_valid_reg;

    logic [CW-1:0] n_eff;
    logic [6:0]    kc;
    logic          is_load;
    logic          slot_ok;

    always_comb begin
        kc = (key_count == 7'd0) ? 7'd1 : key_count;
        if (kc > 7'(SLOT_LIMIT)) kc = 7'(SLOT_LIMIT);
        if (32'(kc) > 32'(KEY_DEPTH)) n_eff = CW'(KEY_DEPTH);
        else n_eff = CW'(kc);
    end

    assign is_load = (q_item.kind == KIND_LOAD);
    assign slot_ok = (32'(q_item.slot) < 32'(KEY_DEPTH));
    assign q_ready = (state_reg == ST_IDLE) && (is_load || !res_valid_reg);
    assign ra_a = aa_reg;
    assign ra_b = ab_reg;

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready && is_load && slot_ok) begin
            t_mem[AW'(q_item.slot)] <= q_item.key_time;
            x_mem[AW'(q_item.slot)] <= q_item.value_x;
            y_mem[AW'(q_item.slot)] <= q_item.value_y;
            z_mem[AW'(q_item.slot)] <= q_item.value_z;
        end
        ta_reg <= t_mem[ra_a];
        xa_reg <= x_mem[ra_a];
        ya_reg <= y_mem[ra_a];
        za_reg <= z_mem[ra_a];
        tb_reg <= t_mem[ra_b];
        xb_reg <= x_mem[ra_b];
        yb_reg <= y_mem[ra_b];
        zb_reg <= z_mem[ra_b];
    end

    // next index modulo the active count
    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] v,
                                               input logic [CW-1:0] n);
        logic [CW:0] s;
        s = (CW+1)'(v) + 1'b1;
        if (s >= (CW+1)'(n)) return '0;
        return AW'(s);
    endfunction

    logic [AW-1:0] last_idx;
    logic          seg_has_next;
    logic [32:0]   rem_sh;
    logic [AW:0]   c_plus;

    assign last_idx = AW'(n_reg - 1'b1);
    assign c_plus = (AW+1)'(c_reg) + 1'b1;
    assign seg_has_next = ((CW+1)'(c_plus) < (CW+1)'(n_reg));
    assign rem_sh = {rem_reg[31:0], 1'b0};

    // sequencer: clamp checks, cached search, divide, blend
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cache_reg <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (res_valid_reg && r_ready) res_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid && q_ready && !is_load) begin
                        q_reg <= q_item.query_time;
                        n_reg <= n_eff;
                        aa_reg <= '0;
                        ab_reg <= AW'(n_eff - 1'b1);
                        state_reg <= ST_RD0;
                    end
                end
                ST_RD0: state_reg <= ST_RDL;
                ST_RDL: state_reg <= ST_CHKL;
                ST_CHKL: begin
                    if ($signed(q_reg) <= $signed(ta_reg)) begin
                        j_reg <= '0;
                        w_reg <= '0;
                        aa_reg <= '0;
                        ab_reg <= '0;
                        state_reg <= ST_FETCH;
                    end else if ($signed(q_reg) >= $signed(tb_reg)) begin
                        j_reg <= last_idx;
                        w_reg <= ONE_WEIGHT;
                        aa_reg <= last_idx;
                        ab_reg <= last_idx;
                        state_reg <= ST_FETCH;
                    end else begin
                        c_reg <= cache_reg;
                        cnt_reg <= '0;
                        state_reg <= ST_SRD;
                    end
                end
                ST_SRD: begin
                    if (32'(c_reg) >= 32'(n_reg)) begin
                        // bring the cached index below the active count
                        c_reg <= AW'(32'(c_reg) - 32'(n_reg));
                    end else begin
                        aa_reg <= c_reg;
                        ab_reg <= seg_has_next ? AW'(c_plus) : c_reg;
                        state_reg <= ST_FWAIT;
                        j_reg <= c_reg;
                    end
                end
                ST_FWAIT: state_reg <= ST_SCHK;
                ST_SCHK: begin
                    if (seg_has_next && $signed(ta_reg) <= $signed(q_reg)
                        && $signed(q_reg) <= $signed(tb_reg)) begin
                        j_reg <= c_reg;
                        if ($signed(tb_reg) > $signed(ta_reg)) begin
                            rem_reg <= 33'($signed(q_reg) - $signed(ta_reg));
                            den_reg <= 33'($signed(tb_reg) - $signed(ta_reg));
                            quo_reg <= '0;
                            bit_reg <= 5'd0;
                            state_reg <= ST_DIV;
                        end else begin
                            w_reg <= ONE_WEIGHT;
                            state_reg <= ST_MUL;
                        end
                    end else if (32'(cnt_reg) + 1 >= 32'(n_reg)) begin
                        j_reg <= last_idx;
                        w_reg <= ONE_WEIGHT;
                        aa_reg <= last_idx;
                        ab_reg <= last_idx;
                        state_reg <= ST_FETCH;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                        c_reg <= wrap_inc(c_reg, n_reg);
                        state_reg <= ST_SRD;
                    end
                end
                ST_FETCH: begin
                    c_reg <= '0;
                    state_reg <= ST_FREAD;
                end
                ST_FREAD: state_reg <= ST_MUL;
                ST_DIV: begin
                    // one quotient bit a cycle, 17 bits, then load the weight
                    if (bit_reg == 5'd17) begin
                        w_reg <= (quo_reg > ONE_WEIGHT) ? ONE_WEIGHT : quo_reg;
                        state_reg <= ST_MUL;
                    end else if (bit_reg == 5'd0) begin
                        if (rem_reg >= den_reg) begin
                            rem_reg <= rem_reg - den_reg;
                            quo_reg <= 17'd1;
                        end else quo_reg <= 17'd0;
                        bit_reg <= 5'd1;
                    end else begin
                        if (rem_sh >= den_reg) begin
                            rem_reg <= rem_sh - den_reg;
                            quo_reg <= {quo_reg[15:0], 1'b1};
                        end else begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[15:0], 1'b0};
                        end
                        bit_reg <= bit_reg + 1'b1;
                    end
                end
                ST_MUL: begin
                    px_reg <= 66'($signed({xb_reg[31], xb_reg}) - $signed({xa_reg[31], xa_reg}))
                              * 66'($signed({1'b0, w_reg}));
                    py_reg <= 66'($signed({yb_reg[31], yb_reg}) - $signed({ya_reg[31], ya_reg}))
                              * 66'($signed({1'b0, w_reg}));
                    pz_reg <= 66'($signed({zb_reg[31], zb_reg}) - $signed({za_reg[31], za_reg}))
                              * 66'($signed({1'b0, w_reg}));
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    res_reg.out_x <= xa_reg + px_reg[47:16];
                    res_reg.out_y <= ya_reg + py_reg[47:16];
                    res_reg.out_z <= za_reg + pz_reg[47:16];
                    res_reg.segment_index <= 6'(j_reg);
                    res_reg.blend_weight <= w_reg;
                    cache_reg <= AW'(6'(j_reg));
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    res_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign r_valid = res_valid_reg;
    assign r_data = res_reg;

endmodule
